[rtl/ladsr_pkg.sv]
`timescale 1ns / 1ps

package ladsr_pkg;

  // Fixed-point envelope constants, amplitude in Q1.16.
  localparam int AMP_W = 17;
  localparam int KNOB_W = 16;
  localparam int SAMPLE_W = 16;
  localparam int STEPS_W = 14;
  localparam int SPAN_PROD_W = STEPS_W + KNOB_W;

  localparam logic [AMP_W-1:0] FULL_SCALE = 17'd65536;
  localparam logic [STEPS_W-1:0] PHASE_SPAN = 14'd15000;
  localparam logic [AMP_W:0] ATTACK_TOP = 18'd64880;
  localparam logic [AMP_W-1:0] RELEASE_FLOOR = 17'd7;

  // Serial divider: one quotient bit per cycle.
  localparam int DIV_STEPS = AMP_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Configuration register map.
  localparam int REG_IDX_W = 2;
  localparam int PADDR_W = REG_IDX_W + 2;
  localparam logic [REG_IDX_W-1:0] REG_ATTACK = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_DECAY = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SUSTAIN = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_RELEASE = 2'd3;

  // Envelope phase chosen for one sample.
  localparam logic [1:0] MODE_RELEASE = 2'd0;
  localparam logic [1:0] MODE_ATTACK = 2'd1;
  localparam logic [1:0] MODE_DECAY = 2'd2;
  localparam logic [1:0] MODE_HOLD = 2'd3;

  typedef struct packed {
    logic load_in;
    logic calc_steps;
    logic div_start;
    logic update;
    logic calc_prod;
    logic load_out;
  } ladsr_cmd_t;

  typedef struct packed {
    logic div_done;
  } ladsr_status_t;

endpackage

[rtl/ladsr_div.sv]
`timescale 1ns / 1ps

module ladsr_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [ladsr_pkg::AMP_W-1:0]          dividend,
  input  logic [ladsr_pkg::STEPS_W-1:0]        divisor,
  output logic                                 done,
  output logic [ladsr_pkg::AMP_W-1:0]          quotient
);
  import ladsr_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [STEPS_W-1:0]   rem;
  logic [STEPS_W:0]     trial;
  logic                 fits;

  // Shift in the next dividend bit and try the subtraction.
  assign trial = {rem, quotient[AMP_W-1]};
  assign fits = trial >= {1'b0, divisor};

  // Control of the restoring iteration.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  // Remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quotient <= dividend;
    end else if (busy) begin
      if (fits) begin
        rem <= STEPS_W'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[STEPS_W-1:0];
      end
      quotient <= {quotient[AMP_W-2:0], fits};
    end
  end

endmodule

[rtl/ladsr_ctrl.sv]
`timescale 1ns / 1ps

module ladsr_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  logic                      out_ready,
  output ladsr_pkg::ladsr_cmd_t     cmd,
  input  ladsr_pkg::ladsr_status_t  status
);
  import ladsr_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_STEPS = 3'd1;
  localparam logic [2:0] S_DIV_GO = 3'd2;
  localparam logic [2:0] S_DIV = 3'd3;
  localparam logic [2:0] S_UPDATE = 3'd4;
  localparam logic [2:0] S_PROD = 3'd5;
  localparam logic [2:0] S_OUT = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  // No beat is taken while reset is held.
  assign in_ready = (state == S_IDLE) && !rst;
  assign out_free = !out_valid || out_ready;

  // Sequencing of one sample through the datapath.
  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load_in = 1'b1;
          state_next = S_STEPS;
        end
      end
      S_STEPS: begin
        cmd.calc_steps = 1'b1;
        state_next = S_DIV_GO;
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (status.div_done) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_PROD;
      end
      S_PROD: begin
        cmd.calc_prod = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      // The output register holds a beat until it is taken.
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/ladsr_datapath.sv]
`timescale 1ns / 1ps

module ladsr_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  ladsr_pkg::ladsr_cmd_t                 cmd,
  output ladsr_pkg::ladsr_status_t              status,
  input  logic                                  gate,
  input  logic signed [ladsr_pkg::SAMPLE_W-1:0] osc_sample,
  input  logic [ladsr_pkg::KNOB_W-1:0]          attack_knob,
  input  logic [ladsr_pkg::KNOB_W-1:0]          decay_knob,
  input  logic [ladsr_pkg::AMP_W-1:0]           sustain_level,
  input  logic [ladsr_pkg::KNOB_W-1:0]          release_knob,
  output logic [ladsr_pkg::AMP_W-1:0]           envelope_level,
  output logic signed [ladsr_pkg::SAMPLE_W-1:0] scaled_sample
);
  import ladsr_pkg::*;

  localparam int PROD_W = AMP_W + 1 + SAMPLE_W;

  // Envelope state.
  logic [AMP_W-1:0] amplitude;
  logic             in_attack;
  logic             in_decay;

  // Per-sample working registers.
  logic [1:0]                 mode;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic [STEPS_W-1:0]         steps;
  logic signed [PROD_W-1:0]   prod_q;

  logic [1:0]             mode_in;
  logic [KNOB_W-1:0]      knob_sel;
  logic [SPAN_PROD_W-1:0] span_prod;
  logic [AMP_W-1:0]       sus;
  logic [AMP_W-1:0]       dividend;
  logic                   div_done;
  logic [AMP_W-1:0]       delta;
  logic [AMP_W:0]         diff;
  logic [AMP_W:0]         sum;
  logic                   borrow;
  logic signed [AMP_W:0]  amp_s;

  assign status.div_done = div_done;

  // Sustain above full scale acts as full scale.
  assign sus = (sustain_level > FULL_SCALE) ? FULL_SCALE : sustain_level;

  // Phase for this sample, taken from the gate and the current flags.
  always_comb begin
    if (!gate) begin
      mode_in = MODE_RELEASE;
    end else if (in_attack) begin
      mode_in = MODE_ATTACK;
    end else if (in_decay) begin
      mode_in = MODE_DECAY;
    end else begin
      mode_in = MODE_HOLD;
    end
  end

  // Knob and dividend for the phase step size.
  always_comb begin
    case (mode)
      MODE_RELEASE: begin
        knob_sel = release_knob;
        dividend = sus;
      end
      MODE_ATTACK: begin
        knob_sel = attack_knob;
        dividend = FULL_SCALE;
      end
      MODE_DECAY: begin
        knob_sel = decay_knob;
        dividend = FULL_SCALE - sus;
      end
      default: begin
        knob_sel = decay_knob;
        dividend = '0;
      end
    endcase
  end

  assign span_prod = PHASE_SPAN * knob_sel;

  ladsr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (steps),
    .done     (div_done),
    .quotient (delta)
  );

  // Candidate amplitudes for each phase.
  assign diff = {1'b0, amplitude} - {1'b0, delta};
  assign borrow = diff[AMP_W];
  assign sum = {1'b0, amplitude} + {1'b0, delta};
  assign amp_s = $signed({1'b0, amplitude});

  // Working registers.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mode <= mode_in;
      sample_q <= osc_sample;
    end
    if (cmd.calc_steps) begin
      steps <= span_prod[SPAN_PROD_W-1:KNOB_W] + 1'b1;
    end
    if (cmd.calc_prod) begin
      prod_q <= amp_s * sample_q;
    end
    if (cmd.load_out) begin
      envelope_level <= amplitude;
      scaled_sample <= prod_q[SAMPLE_W+15:16];
    end
  end

  // Envelope state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude <= '0;
      in_attack <= 1'b1;
      in_decay <= 1'b0;
    end else if (cmd.update) begin
      case (mode)
        MODE_RELEASE: begin
          in_attack <= 1'b1;
          if (borrow || diff[AMP_W-1:0] < RELEASE_FLOOR) begin
            amplitude <= '0;
          end else begin
            amplitude <= diff[AMP_W-1:0];
          end
        end
        MODE_ATTACK: begin
          if (sum > ATTACK_TOP) begin
            amplitude <= FULL_SCALE;
            in_attack <= 1'b0;
            in_decay <= 1'b1;
          end else begin
            amplitude <= sum[AMP_W-1:0];
          end
        end
        MODE_DECAY: begin
          if (borrow || diff[AMP_W-1:0] < sus) begin
            amplitude <= sus;
            in_decay <= 1'b0;
          end else begin
            amplitude <= diff[AMP_W-1:0];
          end
        end
        default: begin
          amplitude <= sus;
        end
      endcase
    end
  end

endmodule

[rtl/linear_adsr_envelope_core.sv]
`timescale 1ns / 1ps
// An accepted input beat passes the step-size calculation, the serial divider that
// forms the phase step size, the envelope update and the product; then its result
// beat is offered. The next sample is taken only after that result is loaded.
// Reset (synchronous, active high): amplitude 0, attack flag set, decay flag clear,
// knobs 0, sustain level 32768, no result pending.

module linear_adsr_envelope_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [ladsr_pkg::PADDR_W-1:0]         paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  gate,
  input  logic signed [ladsr_pkg::SAMPLE_W-1:0] osc_sample,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [ladsr_pkg::AMP_W-1:0]           envelope_level,
  output logic signed [ladsr_pkg::SAMPLE_W-1:0] scaled_sample
);
  import ladsr_pkg::*;

  logic [KNOB_W-1:0]    attack_knob;
  logic [KNOB_W-1:0]    decay_knob;
  logic [AMP_W-1:0]     sustain_level;
  logic [KNOB_W-1:0]    release_knob;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;
  ladsr_cmd_t           cmd;
  ladsr_status_t        status;

  assign pready = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en = psel && penable && pwrite;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      attack_knob <= '0;
      decay_knob <= '0;
      sustain_level <= 17'd32768;
      release_knob <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ATTACK:  attack_knob <= pwdata[KNOB_W-1:0];
        REG_DECAY:   decay_knob <= pwdata[KNOB_W-1:0];
        REG_SUSTAIN: sustain_level <= pwdata[AMP_W-1:0];
        REG_RELEASE: release_knob <= pwdata[KNOB_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register read back.
  always_comb begin
    unique case (reg_idx)
      REG_ATTACK:  prdata = 32'(attack_knob);
      REG_DECAY:   prdata = 32'(decay_knob);
      REG_SUSTAIN: prdata = 32'(sustain_level);
      REG_RELEASE: prdata = 32'(release_knob);
      default:     prdata = '0;
    endcase
  end

  ladsr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  ladsr_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .gate           (gate),
    .osc_sample     (osc_sample),
    .attack_knob    (attack_knob),
    .decay_knob     (decay_knob),
    .sustain_level  (sustain_level),
    .release_knob   (release_knob),
    .envelope_level (envelope_level),
    .scaled_sample  (scaled_sample)
  );

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import ladsr_pkg::*;

  // Envelope arithmetic constants, Q1.16 amplitude.
  localparam int unsigned FULL_AMP = 65536;
  localparam int unsigned SPAN_SAMPLES = 15000;
  localparam int unsigned PEAK_LIMIT = 64880;
  localparam int unsigned SILENCE_LIMIT = 7;

  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE_PAUSE = 4;
  localparam int END_PAUSE = 40;
  localparam int LONG_STALL = 400;
  localparam int BLOCK_ITEMS = 120;
  localparam int DIRECTED_ROWS = 31;

  typedef struct packed {
    logic [AMP_W-1:0]           level;
    logic signed [SAMPLE_W-1:0] scaled;
  } envelope_beat_t;

  // One row of the directed plan: a register write or a sample beat,
  // optionally with a hand-computed result.
  typedef struct packed {
    bit                         wr;
    logic [REG_IDX_W-1:0]       idx;
    logic [31:0]                value;
    logic                       g;
    logic signed [SAMPLE_W-1:0] s;
    bit                         pinned;
    logic [AMP_W-1:0]           lvl;
    logic signed [SAMPLE_W-1:0] scl;
  } plan_row_t;

  localparam plan_row_t PLAN [DIRECTED_ROWS] = '{
    // After reset: one attack step reaches the peak, then decay and hold.
    '{1'b0, REG_ATTACK, 32'd0, 1'b1, 16'sd32767, 1'b1, 17'd65536, 16'sd32767},
    '{1'b0, REG_ATTACK, 32'd0, 1'b1, 16'sh8000, 1'b1, 17'd32768, -16'sd16384},
    '{1'b0, REG_ATTACK, 32'd0, 1'b1, 16'sd0, 1'b1, 17'd32768, 16'sd0},
    '{1'b0, REG_ATTACK, 32'd0, 1'b1, 16'sd1, 1'b1, 17'd32768, 16'sd0},
    // Negative product floors toward minus infinity.
    '{1'b0, REG_ATTACK, 32'd0, 1'b1, -16'sd1, 1'b1, 17'd32768, -16'sd1},
    // Release to zero, then release with nothing left to subtract.
    '{1'b0, REG_ATTACK, 32'd0, 1'b0, 16'sd12345, 1'b1, 17'd0, 16'sd0},
    '{1'b0, REG_ATTACK, 32'd0, 1'b0, 16'sh8000, 1'b1, 17'd0, 16'sd0},
    // Zero sustain: release step is zero, so the level holds.
    '{1'b1, REG_SUSTAIN, 32'd0, 1'b0, 16'sd0, 1'b0, 17'd0, 16'sd0},
    '{1'b0, REG_ATTACK, 32'd0, 1'b1, 16'sd100, 1'b1, 17'd65536, 16'sd100},
    '{1'b0, REG_ATTACK, 32'd0, 1'b0, 16'sh8000, 1'b1, 17'd65536, 16'sh8000},
    '{1'b1, REG_RELEASE, 32'd65535, 1'b0, 16'sd0, 1'b0, 17'd0, 16'sd0},
    '{1'b0, REG_ATTACK, 32'd0, 1'b0, 16'sd32767, 1'b1, 17'd65536, 16'sd32767},
    // Sustain above full scale acts as full scale; decay step is zero.
    '{1'b1, REG_SUSTAIN, 32'h1ffff, 1'b0, 16'sd0, 1'b0, 17'd0, 16'sd0},
    '{1'b0, REG_ATTACK, 32'd0, 1'b1, 16'sd5, 1'b1, 17'd65536, 16'sd5},
    '{1'b0, REG_ATTACK, 32'd0, 1'b1, -16'sd5, 1'b1, 17'd65536, -16'sd5},
    // Release lands just above zero and is floored to silence.
    '{1'b1, REG_SUSTAIN, 32'd65531, 1'b0, 16'sd0, 1'b0, 17'd0, 16'sd0},
    '{1'b1, REG_RELEASE, 32'd0, 1'b0, 16'sd0, 1'b0, 17'd0, 16'sd0},
    '{1'b0, REG_ATTACK, 32'd0, 1'b0, 16'sd32767, 1'b1, 17'd0, 16'sd0},
    // Longest phases.
    '{1'b1, REG_ATTACK, 32'd65535, 1'b0, 16'sd0, 1'b0, 17'd0, 16'sd0},
    '{1'b1, REG_DECAY, 32'd65535, 1'b0, 16'sd0, 1'b0, 17'd0, 16'sd0},
    '{1'b1, REG_RELEASE, 32'd65535, 1'b0, 16'sd0, 1'b0, 17'd0, 16'sd0},
    '{1'b1, REG_SUSTAIN, 32'd3000, 1'b0, 16'sd0, 1'b0, 17'd0, 16'sd0},
    '{1'b0, REG_ATTACK, 32'd0, 1'b1, 16'sh8000, 1'b0, 17'd0, 16'sd0},
    '{1'b0, REG_ATTACK, 32'd0, 1'b1, 16'sd32767, 1'b0, 17'd0, 16'sd0},
    '{1'b0, REG_ATTACK, 32'd0, 1'b0, -16'sd1, 1'b0, 17'd0, 16'sd0},
    // Short attack from a small level, then decay down onto sustain.
    '{1'b1, REG_ATTACK, 32'd1, 1'b0, 16'sd0, 1'b0, 17'd0, 16'sd0},
    '{1'b0, REG_ATTACK, 32'd0, 1'b1, 16'sd12345, 1'b0, 17'd0, 16'sd0},
    '{1'b0, REG_ATTACK, 32'd0, 1'b1, -16'sd12345, 1'b0, 17'd0, 16'sd0},
    '{1'b1, REG_DECAY, 32'd4, 1'b0, 16'sd0, 1'b0, 17'd0, 16'sd0},
    '{1'b0, REG_ATTACK, 32'd0, 1'b1, 16'sd777, 1'b0, 17'd0, 16'sd0},
    '{1'b0, REG_ATTACK, 32'd0, 1'b1, -16'sd777, 1'b0, 17'd0, 16'sd0}
  };

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [PADDR_W-1:0]           paddr = '0;
  logic [31:0]                  pwdata = '0;
  logic [31:0]                  prdata;
  logic                         pready;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic                         gate = 1'b0;
  logic signed [SAMPLE_W-1:0]   osc_sample = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [AMP_W-1:0]             envelope_level;
  logic signed [SAMPLE_W-1:0]   scaled_sample;

  // Hand-computed result that travels with the current input beat.
  bit                           pin_given = 1'b0;
  logic [AMP_W-1:0]             pin_level = '0;
  logic signed [SAMPLE_W-1:0]   pin_scaled = '0;

  int                           send_idle_pct = 0;
  int                           recv_idle_pct = 0;
  bit                           long_stall_req = 1'b0;
  bit                           long_stall_done = 1'b0;
  int                           stall_left = 0;
  int                           cycle_count = 0;
  int                           mismatches = 0;

  // Predictor copy of the configuration and the envelope state.
  logic [KNOB_W-1:0]            set_attack = '0;
  logic [KNOB_W-1:0]            set_decay = '0;
  logic [AMP_W-1:0]             set_sustain = 17'd32768;
  logic [KNOB_W-1:0]            set_release = '0;
  logic [AMP_W-1:0]             env_amp = '0;
  bit                           env_attack = 1'b1;
  bit                           env_decay = 1'b0;

  envelope_beat_t               expected_envelope [$];

  linear_adsr_envelope_core dut (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .gate           (gate),
    .osc_sample     (osc_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .envelope_level (envelope_level),
    .scaled_sample  (scaled_sample)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Number of samples one phase lasts for a given knob.
  function automatic int unsigned phase_len(input logic [KNOB_W-1:0] knob);
    return ((SPAN_SAMPLES * int'(knob)) >> 16) + 1;
  endfunction

  // Advance the envelope by one sample and form the result beat.
  function automatic envelope_beat_t step_envelope(input logic g,
                                                   input logic signed [SAMPLE_W-1:0] s);
    int unsigned    sus;
    int unsigned    step;
    int unsigned    amp;
    longint         prod;
    envelope_beat_t beat;
    sus = (set_sustain > FULL_AMP) ? FULL_AMP : int'(set_sustain);
    amp = env_amp;
    if (!g) begin
      step = sus / phase_len(set_release);
      env_attack = 1'b1;
      if (amp < step || amp - step < SILENCE_LIMIT) begin
        amp = 0;
      end else begin
        amp = amp - step;
      end
    end else if (env_attack) begin
      amp = amp + FULL_AMP / phase_len(set_attack);
      if (amp > PEAK_LIMIT) begin
        amp = FULL_AMP;
        env_attack = 1'b0;
        env_decay = 1'b1;
      end
    end else if (env_decay) begin
      step = (FULL_AMP - sus) / phase_len(set_decay);
      if (amp < step || amp - step < sus) begin
        amp = sus;
        env_decay = 1'b0;
      end else begin
        amp = amp - step;
      end
    end else begin
      amp = sus;
    end
    env_amp = amp[AMP_W-1:0];
    prod = longint'(amp) * longint'(s);
    beat.level = amp[AMP_W-1:0];
    beat.scaled = SAMPLE_W'(prod >>> 16);
    return beat;
  endfunction

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 40) begin
      $display("mismatch at %0t ns: %s", $realtime, what);
    end
  endtask

  // Watch both channels and the register port; predict on every accepted
  // input beat and check every accepted output beat against the oldest one.
  always @(posedge clk) begin : watch
    envelope_beat_t want;
    envelope_beat_t got;
    if (rst) begin
      set_attack <= '0;
      set_decay <= '0;
      set_sustain <= 17'd32768;
      set_release <= '0;
      env_amp <= '0;
      env_attack <= 1'b1;
      env_decay <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[PADDR_W-1:2])
          REG_ATTACK:  set_attack = pwdata[KNOB_W-1:0];
          REG_DECAY:   set_decay = pwdata[KNOB_W-1:0];
          REG_SUSTAIN: set_sustain = pwdata[AMP_W-1:0];
          REG_RELEASE: set_release = pwdata[KNOB_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_envelope.size() == 0) begin
          note_mismatch("output beat with no result pending");
        end else begin
          want = expected_envelope.pop_front();
          got.level = envelope_level;
          got.scaled = scaled_sample;
          if (got.level !== want.level) begin
            note_mismatch($sformatf("envelope_level %0d, expected %0d",
                                    got.level, want.level));
          end
          if (got.scaled !== want.scaled) begin
            note_mismatch($sformatf("scaled_sample %0d, expected %0d",
                                    got.scaled, want.scaled));
          end
        end
      end
      if (in_valid && in_ready) begin
        want = step_envelope(gate, osc_sample);
        if (pin_given) begin
          want.level = pin_level;
          want.scaled = pin_scaled;
        end
        expected_envelope.push_back(want);
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (long_stall_req && !long_stall_done) begin
      out_ready <= 1'b0;
      stall_left <= LONG_STALL;
      long_stall_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one input beat, with random gaps ahead of it, and wait for it to go in.
  task automatic send_beat(input logic g, input logic signed [SAMPLE_W-1:0] s,
                           input bit pin, input logic [AMP_W-1:0] lvl,
                           input logic signed [SAMPLE_W-1:0] scl);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    gate <= g;
    osc_sample <= s;
    pin_given <= pin;
    pin_level <= lvl;
    pin_scaled <= scl;
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  // Stop offering beats and wait until every pending result has come out.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_envelope.size() != 0) @(posedge clk);
    repeat (SETTLE_PAUSE) @(posedge clk);
  endtask

  function automatic logic [KNOB_W-1:0] pick_knob();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return KNOB_W'($urandom_range(65535));
      default: return KNOB_W'($urandom_range(120));
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(15))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return '0;
      3:       return '1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic choose_setting();
    logic [31:0] sus;
    case ($urandom_range(7))
      0:       sus = 0;
      1:       sus = FULL_AMP;
      2:       sus = $urandom_range(131071, 65537);
      3:       sus = $urandom_range(20);
      default: sus = $urandom_range(65536);
    endcase
    write_reg(REG_ATTACK, 32'(pick_knob()));
    write_reg(REG_DECAY, 32'(pick_knob()));
    write_reg(REG_SUSTAIN, sus);
    write_reg(REG_RELEASE, 32'(pick_knob()));
  endtask

  initial begin
    int made;
    int hi;
    int lo;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed plan.
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      if (PLAN[r].wr) begin
        settle();
        write_reg(PLAN[r].idx, PLAN[r].value);
      end else begin
        send_beat(PLAN[r].g, PLAN[r].s, PLAN[r].pinned, PLAN[r].lvl, PLAN[r].scl);
      end
    end

    // Random notes: mostly press/release sequences, some gate noise.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 21;
          recv_idle_pct <= 84;
        end
        1: begin
          send_idle_pct = 84;
          recv_idle_pct <= 21;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
        end
      endcase
      for (int blk = 0; blk < 3; blk++) begin
        settle();
        choose_setting();
        if (ph == 2 && blk == 0) begin
          long_stall_req <= 1'b1;
        end
        made = 0;
        while (made < BLOCK_ITEMS) begin
          if ($urandom_range(9) < 8) begin
            hi = $urandom_range(60, 1);
            lo = $urandom_range(30, 1);
            repeat (hi) send_beat(1'b1, pick_sample(), 1'b0, '0, '0);
            repeat (lo) send_beat(1'b0, pick_sample(), 1'b0, '0, '0);
            made += hi + lo;
          end else begin
            repeat (8) send_beat(1'($urandom_range(1)), pick_sample(), 1'b0, '0, '0);
            made += 8;
          end
        end
      end
    end

    settle();
    repeat (END_PAUSE) @(posedge clk);
    if (expected_envelope.size() != 0) begin
      note_mismatch("results still pending at the end");
    end
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
